// ===== design/m3i_pkg.sv =====
package m3i_pkg;

   // Cofactor sources per adjugate entry: adj = m[a]*m[b] - m[c]*m[d],
   // entries indexed row by row (m00 = 0 .. m22 = 8).
   localparam int unsigned NUM_ENT = 9;
   localparam int unsigned COF_SRC [NUM_ENT][4] = '{
      '{4, 8, 5, 7},
      '{2, 7, 1, 8},
      '{1, 5, 2, 4},
      '{5, 6, 3, 8},
      '{0, 8, 2, 6},
      '{2, 3, 0, 5},
      '{3, 7, 4, 6},
      '{1, 6, 0, 7},
      '{0, 4, 1, 3}
   };

   // Adjugate entries of the first column, which meet row 0 in the determinant
   localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage

// ===== design/matrix3x3_inverse_core.sv =====
// 3x3 matrix inverse by adjugate over determinant, signed fixed point with
// FRAC_BITS fraction bits. One matrix per transfer on req_, one inverse per
// transfer on rsp_, in order. Fully pipelined: a new matrix can be taken every
// cycle except while the pipeline stalls. The nine divider lanes resolve one
// quotient bit per stage. Cofactors and determinant are exact;
// each entry is rounded to nearest (ties away from zero) and saturated. A zero
// determinant gives all-zero entries with the singular flag on rsp_tuser. The
// pipeline stalls only when the output register is full, not taken, and a
// result is ready behind it; bubbles keep draining while rsp_ waits.
module matrix3x3_inverse_core #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   // fields from bit 0: m00 m01 m02 m10 m11 m12 m20 m21 m22, zero padded
   input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // fields from bit 0: inv_m00 .. inv_m22 row by row, zero padded
   output logic [((9*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular
   output logic                              rsp_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   import m3i_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int TW = ((9*W+7)/8)*8;
   localparam int L  = W + 7;            // length of the valid shift register ahead of the output register

   logic                 en;
   logic                 load_out;
   logic [L-1:0]         vld_ff;
   logic                 rsp_valid_ff;
   logic [TW-1:0]        rsp_data_ff;
   logic                 rsp_sing_ff;

   logic signed [W-1:0]   m_in   [9];
   logic signed [2*W:0]   adj    [9];
   logic signed [2*W:0]   adj_d1_ff [9];
   logic signed [2*W:0]   adj_d2_ff [9];
   logic signed [2*W:0]   adj_d3_ff [9];
   logic signed [W-1:0]   m0_d1_ff  [3];
   logic signed [W-1:0]   m0_d2_ff  [3];
   logic signed [2*W:0]   det_cof   [3];
   logic signed [3*W+1:0] det;
   logic                  sing_ff   [W+2];
   logic [W-1:0]          quo    [9];
   logic [TW-1:0]         data_in;

   // advance when the output can take a result or the last stage is a bubble
   assign en         = ~rsp_valid_ff | rsp_tready | ~vld_ff[L-1];
   assign load_out   = en & (~rsp_valid_ff | rsp_tready);
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[L-2:0], req_tvalid};
         end
         if (load_out) begin
            rsp_valid_ff <= vld_ff[L-1];
         end
      end
   end

   for (genvar i = 0; i < 9; i++) begin : g_unpack
      assign m_in[i] = $signed(req_tdata[i*W +: W]);
   end

   // cofactor lanes
   for (genvar i = 0; i < 9; i++) begin : g_cof
      m3i_cof_lane #(.W(W)) u_cof (
         .clock (clock),
         .en    (en),
         .a     (m_in[COF_SRC[i][0]]),
         .b     (m_in[COF_SRC[i][1]]),
         .c     (m_in[COF_SRC[i][2]]),
         .d     (m_in[COF_SRC[i][3]]),
         .cof   (adj[i])
      );
   end

   // row 0 through two registers; adjugate lined up with the determinant
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            m0_d1_ff[k] <= m_in[k];
            m0_d2_ff[k] <= m0_d1_ff[k];
         end
         for (int i = 0; i < 9; i++) begin
            adj_d1_ff[i] <= adj[i];
            adj_d2_ff[i] <= adj_d1_ff[i];
            adj_d3_ff[i] <= adj_d2_ff[i];
         end
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_dcof
      assign det_cof[k] = adj[DET_COF[k]];
   end

   m3i_det #(.W(W)) u_det (
      .clock (clock),
      .en    (en),
      .m0    (m0_d2_ff),
      .cof   (det_cof),
      .det   (det)
   );

   // divider lanes, one per inverse entry
   for (genvar i = 0; i < 9; i++) begin : g_div
      m3i_div_lane #(.W(W), .F(FRAC_BITS)) u_div (
         .clock (clock),
         .en    (en),
         .cof   (adj_d3_ff[i]),
         .det   (det),
         .quo   (quo[i])
      );
   end

   // singular flag travels alongside the divider lanes
   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= (det == '0);
         for (int s = 1; s < W+2; s++) begin
            sing_ff[s] <= sing_ff[s-1];
         end
      end
   end

   // merge: pack the lanes, zero everything on a singular matrix
   always_comb begin
      data_in = '0;
      for (int i = 0; i < 9; i++) begin
         data_in[i*W +: W] = sing_ff[W+1] ? '0 : quo[i];
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_data_ff <= data_in;
         rsp_sing_ff <= sing_ff[W+1];
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sing_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/m3i_cof_lane.sv =====
module m3i_cof_lane #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   a,
   input  logic signed [W-1:0]   b,
   input  logic signed [W-1:0]   c,
   input  logic signed [W-1:0]   d,
   output logic signed [2*W:0]   cof
);

   logic signed [2*W-1:0] p_ff, q_ff;
   logic signed [2*W:0]   cof_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff   <= a * b;
         q_ff   <= c * d;
         cof_ff <= (2*W+1)'(p_ff) - (2*W+1)'(q_ff);
      end
   end

   assign cof = cof_ff;

endmodule

// ===== design/m3i_det.sv =====
module m3i_det #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [W-1:0]   m0 [3],
   input  logic signed [2*W:0]   cof [3],
   output logic signed [3*W+1:0] det
);

   localparam int DW = 3*W + 2;

   // cofactor split into an unsigned low word and a signed high part
   logic signed [2*W:0]  lo_ff [3];
   logic signed [2*W:0]  hi_ff [3];
   logic signed [DW-1:0] prod_ff [3];
   logic signed [DW-1:0] det_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            lo_ff[k]   <= m0[k] * $signed({1'b0, cof[k][W-1:0]});
            hi_ff[k]   <= m0[k] * $signed(cof[k][2*W:W]);
            prod_ff[k] <= (DW'(hi_ff[k]) <<< W) + DW'(lo_ff[k]);
         end
         det_ff <= prod_ff[0] + prod_ff[1] + prod_ff[2];
      end
   end

   assign det = det_ff;

endmodule

// ===== design/m3i_div_lane.sv =====
module m3i_div_lane #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [2*W:0]   cof,
   input  logic signed [3*W+1:0] det,
   output logic [W-1:0]          quo
);

   localparam int XW = 4*W + 4;

   logic signed [XW-1:0] cs, ds;
   logic [XW-1:0]        cmag, dmag;

   logic [XW-1:0] r_ff   [W+1];
   logic [XW-1:0] d2_ff  [W+1];
   logic [W-1:0]  q_ff   [W+1];
   logic          neg_ff [W+1];
   logic          ovf_ff [W+1];
   logic [W-1:0]  quo_ff;

   logic [W-1:0]  lim, qsat;

   always_comb begin
      cs   = XW'(cof);
      ds   = XW'(det);
      cmag = cs[XW-1] ? XW'(-cs) : XW'(cs);
      dmag = ds[XW-1] ? XW'(-ds) : XW'(ds);
   end

   // round to nearest, ties away: floor((2N + D) / 2D)
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0]   <= (cmag << (2*F + 1)) + dmag;
         d2_ff[0]  <= dmag << 1;
         q_ff[0]   <= '0;
         neg_ff[0] <= cof[2*W] ^ det[3*W+1];
         ovf_ff[0] <= 1'b0;
      end
   end

   // one quotient bit per stage, most significant first
   for (genvar k = 0; k < W; k++) begin : g_step
      localparam int B = W - 1 - k;
      logic [XW-1:0] dsh;
      logic          ge, ovf_in;
      always_comb begin
         dsh    = d2_ff[k] << B;
         ge     = r_ff[k] >= dsh;
         ovf_in = (k == 0) ? (r_ff[k] >= (d2_ff[k] << W)) : ovf_ff[k];
      end
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k+1]   <= ge ? r_ff[k] - dsh : r_ff[k];
            d2_ff[k+1]  <= d2_ff[k];
            q_ff[k+1]   <= q_ff[k] | (W'(ge) << B);
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_in;
         end
      end
   end

   always_comb begin
      lim  = neg_ff[W] ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
      qsat = (ovf_ff[W] || (q_ff[W] > lim)) ? lim : q_ff[W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= neg_ff[W] ? W'(-qsat) : qsat;
      end
   end

   assign quo = quo_ff;

endmodule
